// ===== rtl/core/rle8_sprite_stream_decoder_core_assert.svh =====
// Assertion macros for the RLE8 sprite decoder
`ifndef RLE8_SPRITE_STREAM_DECODER_CORE_ASSERT_SVH
`define RLE8_SPRITE_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSD_ASSERT(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("assertion failed");
`define RSD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSD_ASSERT(label, clk_s, rst_s, prop)
`define RSD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the RLE8 sprite stream decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam logic [7:0] MAGIC_0 = 8'h52;
    localparam logic [7:0] MAGIC_1 = 8'h44;
    localparam int unsigned CAP_W = 25;
    localparam logic [CAP_W-1:0] CAP_RESET = 25'd16777216;
    localparam logic [1:0] CFG_CAPACITY = 2'd0;

    typedef enum logic [4:0] {
        PH_HDR  = 5'b00001,
        PH_PASS = 5'b00010,
        PH_RAW  = 5'b00100,
        PH_RLE  = 5'b01000,
        PH_FAIL = 5'b10000
    } phase_t;

    typedef enum logic [5:0] {
        TK_CTRL  = 6'b000001,
        TK_FILL  = 6'b000010,
        TK_CNT12 = 6'b000100,
        TK_CNTHI = 6'b001000,
        TK_CNTLO = 6'b010000,
        TK_LIT   = 6'b100000
    } tok_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_HDR   = 8'b00000010,
        ST_MUL0  = 8'b00000100,
        ST_MUL1  = 8'b00001000,
        ST_FLUSH = 8'b00010000,
        ST_DONE  = 8'b00100000,
        ST_OUT   = 8'b01000000,
        ST_BYTE  = 8'b10000000
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;   // latch incoming beat
        logic proc_byte;   // run phase step for latched byte
        logic mul0;        // low partial product
        logic mul1;        // high partial product and phase decision
        logic flush;       // emit one header byte as passthrough pixel
        logic finish;      // build completion and clear stream
        logic out_pop;     // output beat taken
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hdr_full;    // 16th header byte latched
        logic is_last;
        logic in_hdr;
        logic pass_hdr;    // header lacked magic
        logic flush_end;   // last header byte flushed
        logic out_busy;
        logic emits;       // pending byte produces an output beat
    } dp_sts_t;

endpackage

// ===== rtl/core/rsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsd_ctrl
// Sequencer: steps the datapath through header, multiply, flush, byte decode and output.
// ----------------------------------------------------------------------------
module rsd_ctrl
    import rsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    input  logic    m_fire
);
    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        cmd.out_pop = m_fire;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !sts.out_busy;
                if (s_tvalid && s_tready)
                begin
                    cmd.take_byte = 1'b1;
                    state_next = sts.in_hdr ? ST_HDR : ST_BYTE;
                end
            end
            ST_HDR:
            begin
                if (sts.hdr_full)
                    state_next = ST_MUL0;
                else if (sts.is_last)
                    state_next = ST_DONE;
                else
                    state_next = ST_IDLE;
            end
            ST_MUL0:
            begin
                cmd.mul0 = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = sts.pass_hdr ? ST_FLUSH : (sts.is_last ? ST_DONE : ST_IDLE);
            end
            ST_FLUSH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.flush = 1'b1;
                    if (sts.flush_end)
                        state_next = sts.is_last ? ST_DONE : ST_IDLE;
                end
            end
            ST_BYTE:
            begin
                if (!(sts.emits && sts.out_busy))
                begin
                    cmd.proc_byte = 1'b1;
                    state_next = sts.is_last ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/rsd_datapath.sv =====
// ----------------------------------------------------------------------------
// rsd_datapath
// Header store, pixel counters, token decoder and output register.
// ----------------------------------------------------------------------------
`include "rle8_sprite_stream_decoder_core_assert.svh"
module rsd_datapath
    import rsd_pkg::*;
#(
    parameter logic [31:0] MAX_PIXELS = 32'd16777216
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic [CAP_W-1:0]  capacity,
    output logic              out_valid,
    output logic [124:0]      out_data
);
    localparam logic [32:0] MAXP33 = {1'b0, MAX_PIXELS};
    localparam logic [124:0] LAST_BIT = {1'b1, 124'd0};

    phase_t      phase_reg;
    tok_t        tok_reg;
    logic [4:0]  hidx_reg;
    logic [7:0]  hdr_reg [HDR_BYTES];
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] total_reg;
    logic [31:0] done_reg;
    logic [7:0]  ctrl_reg;
    logic [7:0]  fill_reg;
    logic [19:0] acc_reg;
    logic [11:0] lit_reg;
    logic [31:0] plo_reg;
    logic [3:0]  fidx_reg;
    logic [124:0] odata_reg;

    logic [31:0] w_word, h_word, eff_cap, room;
    logic [32:0] cap33;
    logic        magic;

    // output fields: kind, pv, rl, st, w, h, dc, last
    function automatic logic [124:0] pack(
        input logic k, input logic [7:0] pv, input logic [19:0] rl, input logic st,
        input logic [31:0] w, input logic [31:0] h, input logic [24:0] dc);
        pack = {1'b0, 3'b0, dc, h, w, st, rl, pv, k};
    endfunction

    assign w_word = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
    assign h_word = {hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8]};
    assign cap33 = {8'd0, capacity};
    assign eff_cap = (cap33 < MAXP33) ? {7'd0, capacity} : MAX_PIXELS;
    assign magic = (hdr_reg[0] == MAGIC_0) && (hdr_reg[1] == MAGIC_1);
    assign room = total_reg - done_reg;

    // decode the pending run-phase byte
    logic        emit_c;
    logic [7:0]  epv_c;
    logic [19:0] erl_c;
    tok_t        tok_c;
    logic [7:0]  fill_c;
    logic [19:0] acc_c;
    logic [11:0] lit_c;
    logic [31:0] add_c;
    logic        rcnt;
    logic [19:0] rlen;
    logic [7:0]  b;

    always_comb
    begin
        b = byte_reg;
        emit_c = 1'b0;
        epv_c = b;
        erl_c = 20'd1;
        tok_c = tok_reg;
        fill_c = fill_reg;
        acc_c = acc_reg;
        lit_c = lit_reg;
        add_c = 32'd0;
        rcnt = 1'b0;
        rlen = 20'd0;
        case (phase_reg)
            PH_PASS:
            begin
                if (done_reg < eff_cap)
                begin
                    emit_c = 1'b1;
                    add_c = 32'd1;
                end
            end
            PH_RAW:
            begin
                if (done_reg < total_reg)
                begin
                    emit_c = 1'b1;
                    add_c = 32'd1;
                end
            end
            PH_RLE:
            begin
                if (done_reg < total_reg)
                begin
                    case (tok_reg)
                        TK_CTRL:
                        begin
                            if (b[7])
                            begin
                                if (b[6])
                                begin
                                    fill_c = 8'd0;
                                    if (b[5]) tok_c = TK_CNTHI;
                                    else if (b[4]) tok_c = TK_CNT12;
                                    else
                                    begin
                                        rcnt = 1'b1;
                                        rlen = {16'd0, b[3:0]};
                                    end
                                end
                                else
                                    tok_c = TK_FILL;
                            end
                            else if (b[4])
                                tok_c = TK_CNT12;
                            else
                            begin
                                lit_c = {8'd0, b[3:0]};
                                tok_c = (b[3:0] != 4'd0) ? TK_LIT : TK_CTRL;
                            end
                        end
                        TK_FILL:
                        begin
                            fill_c = b;
                            if (ctrl_reg[5]) tok_c = TK_CNTHI;
                            else if (ctrl_reg[4]) tok_c = TK_CNT12;
                            else
                            begin
                                rcnt = 1'b1;
                                rlen = {16'd0, ctrl_reg[3:0]};
                            end
                        end
                        TK_CNT12:
                        begin
                            if (ctrl_reg[7])
                            begin
                                rcnt = 1'b1;
                                rlen = {8'd0, ctrl_reg[3:0], b};
                            end
                            else
                            begin
                                lit_c = {ctrl_reg[3:0], b};
                                tok_c = (lit_c != 12'd0) ? TK_LIT : TK_CTRL;
                            end
                        end
                        TK_CNTHI:
                        begin
                            acc_c = {ctrl_reg[3:0], b, 8'd0};
                            tok_c = TK_CNTLO;
                        end
                        TK_CNTLO:
                        begin
                            acc_c = {acc_reg[19:8], b};
                            rcnt = 1'b1;
                            rlen = acc_c;
                        end
                        TK_LIT:
                        begin
                            emit_c = 1'b1;
                            add_c = 32'd1;
                            lit_c = lit_reg - 12'd1;
                            if (lit_c == 12'd0) tok_c = TK_CTRL;
                        end
                        default: tok_c = TK_CTRL;
                    endcase
                    if (rcnt)
                    begin
                        tok_c = TK_CTRL;
                        erl_c = ({12'd0, rlen} < room) ? rlen : room[19:0];
                        epv_c = fill_c;
                        if (erl_c != 20'd0)
                        begin
                            emit_c = 1'b1;
                            add_c = {12'd0, erl_c};
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign sts.hdr_full = (hidx_reg == 5'(HDR_BYTES));
    assign sts.is_last = last_reg;
    assign sts.in_hdr = (phase_reg == PH_HDR);
    assign sts.pass_hdr = (hidx_reg == 5'(HDR_BYTES)) && !magic;
    assign sts.flush_end = (fidx_reg == 4'(HDR_BYTES - 1));
    assign sts.out_busy = out_valid;
    assign sts.emits = emit_c;
    assign out_data = odata_reg;

    logic [31:0] prod_hi;
    assign prod_hi = plo_reg + {w_word[15:0] * h_word[31:16], 16'd0}
                   + {w_word[31:16] * h_word[15:0], 16'd0};

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            byte_reg <= in_byte;
            if (phase_reg == PH_HDR)
                hdr_reg[hidx_reg[3:0]] <= in_byte;
        end
        if (cmd.mul0)
            plo_reg <= w_word[15:0] * h_word[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            tok_reg <= TK_CTRL;
            hidx_reg <= '0;
            last_reg <= 1'b0;
            total_reg <= '0;
            done_reg <= '0;
            ctrl_reg <= '0;
            fill_reg <= '0;
            acc_reg <= '0;
            lit_reg <= '0;
            fidx_reg <= '0;
            out_valid <= 1'b0;
            odata_reg <= '0;
        end
        else
        begin
            if (cmd.out_pop)
                out_valid <= 1'b0;
            if (cmd.take_byte)
            begin
                last_reg <= in_last;
                if (phase_reg == PH_HDR)
                    hidx_reg <= hidx_reg + 5'd1;
            end
            if (cmd.mul1)
            begin
                total_reg <= prod_hi;
                fidx_reg <= '0;
                if (!magic)
                    phase_reg <= PH_PASS;
                else if (prod_hi > eff_cap)
                    phase_reg <= PH_FAIL;
                else
                    phase_reg <= (hdr_reg[2] == 8'd0) ? PH_RAW : PH_RLE;
            end
            if (cmd.flush)
            begin
                fidx_reg <= fidx_reg + 4'd1;
                if (sts.flush_end)
                    hidx_reg <= '0;
                if (done_reg < eff_cap)
                begin
                    // final flushed beat: header end or capacity reached, and the source byte not the last
                    done_reg <= done_reg + 32'd1;
                    out_valid <= 1'b1;
                    odata_reg <= pack(1'b0, hdr_reg[fidx_reg], 20'd1, 1'b0, '0, '0, '0)
                               | {(!last_reg && (sts.flush_end ||
                                                 (done_reg + 32'd1 == eff_cap))), 124'd0};
                end
            end
            if (cmd.proc_byte)
            begin
                tok_reg <= tok_c;
                fill_reg <= fill_c;
                acc_reg <= acc_c;
                lit_reg <= lit_c;
                done_reg <= done_reg + add_c;
                if (phase_reg == PH_RLE && tok_reg == TK_CTRL && done_reg < total_reg)
                    ctrl_reg <= byte_reg;
                if (emit_c)
                begin
                    out_valid <= 1'b1;
                    odata_reg <= pack(1'b0, epv_c, erl_c, 1'b0, '0, '0, '0)
                               | {!last_reg, 124'd0};
                end
            end
            if (cmd.finish)
            begin
                out_valid <= 1'b1;
                case (phase_reg)
                    PH_HDR:  odata_reg <= pack(1'b1, '0, '0, 1'b1, '0, '0, '0) | LAST_BIT;
                    PH_PASS: odata_reg <= pack(1'b1, '0, '0, 1'b0, '0, '0, done_reg[24:0])
                                        | LAST_BIT;
                    PH_FAIL: odata_reg <= pack(1'b1, '0, '0, 1'b1, w_word, h_word, '0)
                                        | LAST_BIT;
                    default: odata_reg <= pack(1'b1, '0, '0, 1'b0, w_word, h_word,
                                               done_reg[24:0]) | LAST_BIT;
                endcase
                phase_reg <= PH_HDR;
                tok_reg <= TK_CTRL;
                hidx_reg <= '0;
                total_reg <= '0;
                done_reg <= '0;
                ctrl_reg <= '0;
                fill_reg <= '0;
                acc_reg <= '0;
                lit_reg <= '0;
            end
        end
    end

    `RSD_ASSERT(a_done_le_total, clk, rst_n,
        !(phase_reg == PH_RLE || phase_reg == PH_RAW) || done_reg <= total_reg)
    `RSD_ASSERT(a_hidx_range, clk, rst_n, hidx_reg <= 5'(HDR_BYTES))
    `RSD_ASSERT_NEXT(a_finish_clears, clk, rst_n, cmd.finish, phase_reg == PH_HDR)
endmodule

// ===== rtl/core/rle8_sprite_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rle8_sprite_stream_decoder_core
// Streaming decoder for RD run-length sprites with 8-bit palette pixels.
// ----------------------------------------------------------------------------
// One source byte per beat. Each header byte is accepted, then checked; after the 16th
// byte the size product is formed from 16x16 partial products, low then high, and a
// header without magic is flushed as up to 16 pixel beats, each waiting for the
// output register to drain. Run-phase bytes are accepted, then decoded into the
// output register; after a byte that emits a beat, the next byte waits for the
// output register to empty. After the last byte the completion beat is built in
// the output register and then waits there until it is taken. A new byte is
// taken only once the output register is empty.
`include "rle8_sprite_stream_decoder_core_assert.svh"
module rle8_sprite_stream_decoder_core
    import rsd_pkg::*;
#(
    parameter logic [31:0] MAX_PIXELS = 32'd16777216
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] src_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // pixel_value, run_length, status, image_width,
                                    // image_height, decoded_count (low bit up)
    output logic         m_tuser,   // kind
    output logic         m_tlast,   // last_result
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic [CAP_W-1:0] cap_reg;
    logic [124:0] od;
    logic m_fire;

    assign pready = 1'b1;
    assign prdata = (paddr == {CFG_CAPACITY[1:0]}) ? {7'd0, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && (paddr == CFG_CAPACITY))
            cap_reg <= pwdata[CAP_W-1:0];
    end

    assign m_fire = m_tvalid && m_tready;
    assign m_tuser = od[0];
    assign m_tdata = {2'd0, od[118:1]};
    assign m_tlast = od[124];

    rsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .m_fire   (m_fire)
    );

    rsd_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .capacity  (cap_reg),
        .out_valid (m_tvalid),
        .out_data  (od)
    );

    `RSD_ASSERT_NEXT(a_hold_out, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `RSD_ASSERT(a_no_take_busy, clk, rst_n, !(s_tready && m_tvalid))
    `RSD_ASSERT(a_cmd_excl, clk, rst_n,
        $onehot0({cmd.take_byte, cmd.proc_byte, cmd.mul0, cmd.mul1, cmd.flush, cmd.finish}))
endmodule
